>>> src/scg_pkg.sv
// Shared constants, types and angle table for the spherical cap grow pipeline.
package scg_pkg;

   localparam int FRAC_BITS_DEFAULT = 29;
   localparam int STEPS = 32;

   localparam logic signed [63:0] Q_ONE       = 64'sh0000_0001_0000_0000;
   localparam logic signed [63:0] Q_TWO       = 64'sh0000_0002_0000_0000;
   localparam logic signed [63:0] Q_PI        = 64'sd13493037705;
   localparam logic signed [63:0] Q_HALF_PI   = 64'sd6746518852;
   localparam logic signed [63:0] CORDIC_GAIN = 64'sd2608131496;

   typedef enum logic [1:0] {
      OUT_NORMAL = 2'd0,
      OUT_WHOLE  = 2'd1,
      OUT_NULL   = 2'd2
   } outcome_type;

   function automatic logic signed [63:0] atan_step(input int i);
      logic signed [63:0] r;
      case (i)
         0:       r = 64'sd3373259426;
         1:       r = 64'sd1991351318;
         2:       r = 64'sd1052175346;
         3:       r = 64'sd534100635;
         4:       r = 64'sd268086748;
         5:       r = 64'sd134174063;
         6:       r = 64'sd67103403;
         7:       r = 64'sd33553749;
         8:       r = 64'sd16777131;
         9:       r = 64'sd8388597;
         10:      r = 64'sd4194303;
         11:      r = 64'sd2097152;
         default: r = 64'sd1 <<< (32 - i);
      endcase
      return r;
   endfunction

endpackage

>>> src/scg_sqrt.sv
// Pipelined chord length: product of a and 2-a, then a bit-per-stage integer square root.
module scg_sqrt import scg_pkg::*; #(
   parameter int SIDE_W = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [63:0]        in_a,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [63:0]        out_a,
   output logic [63:0]        out_y,
   output logic [SIDE_W-1:0]  out_side
);

   logic [31:0]       a31;
   logic [32:0]       b31;
   logic              v_ff   [0:STEPS];
   logic [63:0]       x_ff   [0:STEPS];
   logic [63:0]       res_ff [0:STEPS];
   logic [63:0]       a_ff   [0:STEPS];
   logic [SIDE_W-1:0] side_ff[0:STEPS];

   assign a31 = in_a[32:1];
   assign b31 = 33'h1_0000_0000 - {1'b0, a31};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         x_ff[0]    <= 64'(a31 * b31);
         res_ff[0]  <= '0;
         a_ff[0]    <= in_a;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic [63:0] bit_w;
      logic [63:0] t;
      logic [63:0] x_in;
      logic [63:0] res_in;
      always_comb begin
         bit_w = 64'd1 << (62 - 2 * k);
         t = res_ff[k] + bit_w;
         if (x_ff[k] >= t) begin
            x_in   = x_ff[k] - t;
            res_in = (res_ff[k] >> 1) + bit_w;
         end else begin
            x_in   = x_ff[k];
            res_in = res_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (adv) begin
            x_ff[k+1]    <= x_in;
            res_ff[k+1]  <= res_in;
            a_ff[k+1]    <= a_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_a     = a_ff[STEPS];
   assign out_y     = res_ff[STEPS] << 1;
   assign out_side  = side_ff[STEPS];

endmodule

>>> src/scg_vec.sv
// Pipelined vectoring CORDIC: angle of (1-a, y) in [0, pi], one iteration per stage.
module scg_vec import scg_pkg::*; #(
   parameter int SIDE_W = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [63:0]        in_a,
   input  logic [63:0]        in_y,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic signed [63:0] out_z,
   output logic [SIDE_W-1:0]  out_side
);

   logic                v_ff   [0:STEPS];
   logic signed [63:0]  x_ff   [0:STEPS];
   logic signed [63:0]  y_ff   [0:STEPS];
   logic signed [63:0]  z_ff   [0:STEPS];
   logic [SIDE_W-1:0]   side_ff[0:STEPS];
   logic signed [63:0]  x0;

   assign x0 = Q_ONE - $signed(in_a);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         if (x0 < 0) begin
            x_ff[0] <= $signed(in_y);
            y_ff[0] <= -x0;
            z_ff[0] <= Q_HALF_PI;
         end else begin
            x_ff[0] <= x0;
            y_ff[0] <= $signed(in_y);
            z_ff[0] <= '0;
         end
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      logic signed [63:0] ys;
      logic signed [63:0] xs;
      assign ys = y_ff[i] >>> i;
      assign xs = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (adv) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + atan_step(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - atan_step(i);
            end
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_z     = z_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

>>> src/scg_rot.sv
// Pipelined rotation CORDIC: cosine of an angle in [0, pi/2], one iteration per stage.
module scg_rot import scg_pkg::*; #(
   parameter int SIDE_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic signed [63:0] in_t,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic signed [63:0] out_c,
   output logic [SIDE_W-1:0]  out_side
);

   logic                v_ff   [0:STEPS];
   logic signed [63:0]  x_ff   [0:STEPS];
   logic signed [63:0]  y_ff   [0:STEPS];
   logic signed [63:0]  z_ff   [0:STEPS];
   logic [SIDE_W-1:0]   side_ff[0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
      if (adv) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= in_t;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      logic signed [63:0] ys;
      logic signed [63:0] xs;
      assign ys = y_ff[i] >>> i;
      assign xs = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (adv) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - atan_step(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + atan_step(i);
            end
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_c     = x_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

>>> src/spherical_cap_grow.sv
// Spherical cap grow top level: input scaling, angle classification and output register.
//
// Usage: each transfer on req_ carries one signed cap size (Q3.29 by default, FRAC_BITS).
// The block turns it into a cap angle, adds the angle held in the csr_ register
// and returns the new signed cap size on rsp_, with rsp_tuser telling whether the
// result is a normal conversion, the whole sphere or a null cap.
// csr_wr_en loads csr_wr_data (signed radians) into the grow angle register; write only while idle.
// Throughput: one transfer per cycle while rsp_tready does not stall the pipe, fully pipelined.
// Stages from req_ transfer to rsp_tvalid: one input stage, the
// product and 32 square-root stages, the vectoring CORDIC (33), two angle stages,
// the rotation CORDIC (33) and the output register.
// All stages advance together; when rsp_tready is low with a result waiting,
// the whole pipe holds and req_tready drops, nothing is lost or repeated.
// Reset clears every valid bit and the grow angle to zero.
module spherical_cap_grow import scg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] cap_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] new_cap_value
   output logic [1:0]  rsp_tuser,   // [1:0] outcome
   input  logic        csr_wr_en,
   input  logic [32:0] csr_wr_data
);

   localparam int SH     = 32 - FRAC_BITS;
   localparam int SHL    = (SH > 0) ? SH : 0;
   localparam int SHR    = (SH < 0) ? -SH : 0;
   localparam int RND_SH = (SHL > 0) ? SHL - 1 : 0;
   localparam logic [63:0] RND = (SHL > 0) ? (64'd1 << RND_SH) : 64'd0;

   function automatic logic [63:0] to_q32_mag(input logic [63:0] mag);
      return (mag << SHL) >> SHR;
   endfunction

   function automatic logic [31:0] to_out(input logic [63:0] m);
      logic [63:0] mag;
      mag = ((m + RND) >> SHL) << SHR;
      if (mag > 64'h7FFF_FFFF) begin
         mag = 64'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   logic                adv;
   logic signed [63:0]  grow_q_ff;
   logic [63:0]         gmag;

   logic                in_neg;
   logic [63:0]         in_mag;
   logic                s0_v_ff;
   logic [63:0]         s0_a_ff;
   logic                s0_neg_ff;

   logic                sq_v;
   logic [63:0]         sq_a;
   logic [63:0]         sq_y;
   logic [2:0]          sq_side;

   logic                vc_v;
   logic signed [63:0]  vc_z;
   logic [2:0]          vc_side;

   logic signed [63:0]  theta;
   logic signed [63:0]  tn_in;
   logic                s1_v_ff;
   logic signed [63:0]  s1_tn_ff;
   logic                s1_neg_ff;

   logic signed [63:0]  u;
   logic signed [63:0]  t_in;
   outcome_type         code_in;
   logic                s2_v_ff;
   logic signed [63:0]  s2_t_ff;
   logic [3:0]          s2_side_ff;

   logic                rt_v;
   logic signed [63:0]  rt_c;
   logic [3:0]          rt_side;

   logic signed [63:0]  c;
   logic signed [63:0]  m;
   logic [31:0]         mag_out;
   logic [31:0]         data_in;
   logic                rsp_tvalid_ff;
   logic [31:0]         rsp_tdata_ff;
   logic [1:0]          rsp_tuser_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // grow angle scaled to Q32
   assign gmag = to_q32_mag(csr_wr_data[32] ? 64'(-$signed(csr_wr_data))
                                           : {31'd0, csr_wr_data});
   always_ff @(posedge clock) begin
      if (reset) begin
         grow_q_ff <= '0;
      end else if (csr_wr_en) begin
         grow_q_ff <= csr_wr_data[32] ? -$signed(gmag) : $signed(gmag);
      end
   end

   assign in_neg = req_tdata[31];
   assign in_mag = to_q32_mag(in_neg ? 64'(-$signed(req_tdata)) : {32'd0, req_tdata});

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_tvalid;
      end
      if (adv) begin
         s0_a_ff   <= in_mag;
         s0_neg_ff <= in_neg;
      end
   end

   // side: {neg, size at or beyond two, zero size}
   scg_sqrt #(.SIDE_W(3)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s0_v_ff),
      .in_a      (s0_a_ff),
      .in_side   ({s0_neg_ff, s0_a_ff >= 64'(Q_TWO), s0_a_ff == 64'd0}),
      .out_valid (sq_v),
      .out_a     (sq_a),
      .out_y     (sq_y),
      .out_side  (sq_side)
   );

   scg_vec #(.SIDE_W(3)) u_vec (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_v),
      .in_a      (sq_a),
      .in_y      (sq_y),
      .in_side   (sq_side),
      .out_valid (vc_v),
      .out_z     (vc_z),
      .out_side  (vc_side)
   );

   always_comb begin
      if (vc_side[1]) begin
         theta = Q_PI;
      end else if (vc_side[0]) begin
         theta = '0;
      end else begin
         theta = vc_z;
      end
      tn_in = (vc_side[2] ? -theta : theta) + grow_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= vc_v;
      end
      if (adv) begin
         s1_tn_ff  <= tn_in;
         s1_neg_ff <= vc_side[2];
      end
   end

   always_comb begin
      if ((!s1_neg_ff && s1_tn_ff >= Q_PI) || (s1_neg_ff && s1_tn_ff >= 0)) begin
         code_in = OUT_WHOLE;
      end else if ((!s1_neg_ff && s1_tn_ff < 0) || (s1_neg_ff && s1_tn_ff <= -Q_PI)) begin
         code_in = OUT_NULL;
      end else begin
         code_in = OUT_NORMAL;
      end
      u    = (s1_tn_ff < 0) ? -s1_tn_ff : s1_tn_ff;
      t_in = (u > Q_HALF_PI) ? Q_PI - u : u;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         s2_t_ff    <= t_in;
         s2_side_ff <= {code_in, s1_tn_ff < 0, u > Q_HALF_PI};
      end
   end

   // side: {outcome, result negative, cosine mirrored}
   scg_rot #(.SIDE_W(4)) u_rot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s2_v_ff),
      .in_t      (s2_t_ff),
      .in_side   (s2_side_ff),
      .out_valid (rt_v),
      .out_c     (rt_c),
      .out_side  (rt_side)
   );

   always_comb begin
      c = rt_side[0] ? -rt_c : rt_c;
      m = Q_ONE - c;
      if (m < 0) begin
         m = '0;
      end
      if (m > Q_TWO) begin
         m = Q_TWO;
      end
      mag_out = to_out(m);
      case (outcome_type'(rt_side[3:2]))
         OUT_WHOLE: data_in = to_out(64'(Q_TWO));
         OUT_NULL:  data_in = '0;
         default:   data_in = rt_side[1] ? 32'd0 - mag_out : mag_out;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= rt_v;
      end
      if (adv) begin
         rsp_tdata_ff <= data_in;
         rsp_tuser_ff <= rt_side[3:2];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
